// ===== src/p2b_pkg.sv =====
// p2b_pkg: shared types, codes and constants of the pixel to braille block.
// No dependencies; every other file but p2b_ram uses it through scoped names.
package p2b_pkg;

	localparam int PIXEL_W     = 32;
	localparam int CODE_W      = 14;
	localparam int ROW_CELLS_W = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int LIMIT_W     = 16;
	localparam int SUM_W       = 10;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_CELLS = 3'd0,
		CFG_INVERT    = 3'd1,
		CFG_SPACES    = 3'd2,
		CFG_INTENSITY = 3'd3,
		CFG_ALPHA     = 3'd4,
		CFG_WEIGHT    = 3'd5
	} cfg_idx_t;

	localparam logic [ROW_CELLS_W-1:0] ROW_CELLS_RST = 12'd30;
	localparam logic [7:0]             INTENSITY_RST = 8'd128;
	localparam logic [7:0]             ALPHA_RST     = 8'd64;
	localparam logic [7:0]             WEIGHT_RST    = 8'd3;
	localparam logic [LIMIT_W-1:0]     LIMIT_RST     = 16'd384;

	localparam logic [CODE_W-1:0] BRAILLE_BASE = 14'h2800;
	localparam logic [CODE_W-1:0] EMPTY_CODE   = 14'h2804;
	localparam logic [CODE_W-1:0] CODE_SPACE   = 14'd32;
	localparam logic [CODE_W-1:0] CODE_CR      = 14'd13;
	localparam logic [CODE_W-1:0] CODE_LF      = 14'd10;

	typedef enum logic [1:0] {
		OSEL_CELL  = 2'd0,
		OSEL_SPACE = 2'd1,
		OSEL_CR    = 2'd2,
		OSEL_LF    = 2'd3
	} out_sel_t;

	typedef struct packed {
		logic [ROW_CELLS_W-1:0] row_cells;
		logic                   invert;
		logic                   use_spaces;
		logic [7:0]             alpha_thr;
		logic [LIMIT_W-1:0]     limit;     // intensity threshold times weight
	} cfg_t;

	typedef struct packed {
		logic     capture;
		logic     wr_en;
		logic     load_out;
		out_sel_t out_sel;
		logic     out_last;
		logic     step;
	} dp_cmd_t;

	typedef struct packed {
		logic emit;
		logic row_end;
		logic out_free;
		logic use_spaces;
	} dp_stat_t;

	// dot bits 0..7 -> braille bits, empty cell maps to the blank-ish 0x2804
	function automatic logic [CODE_W-1:0] braille_code(input logic [7:0] v);
		logic [7:0] r;
		r = {v[7], v[3], v[6], v[5], v[4], v[2], v[1], v[0]};
		if (v == 8'd0)
			braille_code = EMPTY_CODE;
		else
			braille_code = BRAILLE_BASE | {6'd0, r};
	endfunction

endpackage

// ===== src/p2b_pixel_if.sv =====
// p2b_pixel_if: pixel input channel, valid/ready with one RGBA word.
// Depends on p2b_pkg for the payload width.
interface p2b_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [p2b_pkg::PIXEL_W-1:0]  pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

// ===== src/p2b_char_if.sv =====
// p2b_char_if: character output channel, valid/ready with code and last flag.
// Depends on p2b_pkg for the payload width.
interface p2b_char_if;
	logic                        valid;
	logic                        ready;
	logic [p2b_pkg::CODE_W-1:0]  char_code;
	logic                        last;

	modport source(output valid, output char_code, output last, input ready);
	modport sink(input valid, input char_code, input last, output ready);
endinterface

// ===== src/p2b_cfg_if.sv =====
// p2b_cfg_if: configuration write channel, register index plus write data.
// Depends on p2b_pkg for the field widths.
interface p2b_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [p2b_pkg::CFG_IDX_W-1:0]   index;
	logic [p2b_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/p2b_ram.sv =====
// p2b_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module p2b_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end
endmodule

// ===== src/p2b_cfg.sv =====
// p2b_cfg: configuration registers and the precomputed threshold product.
// Depends on p2b_pkg and p2b_cfg_if.
module p2b_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	p2b_cfg_if.sink              cfg,
	output p2b_pkg::cfg_t        cfg_o
);
	logic [p2b_pkg::ROW_CELLS_W-1:0] row_cells_q;
	logic                            invert_q;
	logic                            spaces_q;
	logic [7:0]                      intensity_q;
	logic [7:0]                      alpha_q;
	logic [7:0]                      weight_q;   // zero already mapped to one
	logic [p2b_pkg::LIMIT_W-1:0]     limit_q;

	logic       wr;
	logic [7:0] wdata8;
	logic [7:0] mul_a;
	logic [7:0] mul_b;
	logic [7:0] weight_new;

	assign cfg.ready  = 1'b1;
	assign wr         = cfg.valid;
	assign wdata8     = cfg.data[7:0];
	assign weight_new = (wdata8 == 8'd0) ? 8'd1 : wdata8;

	// sum/weight < thr  <=>  sum < thr*weight, product follows every intensity or weight write
	always_comb begin
		mul_a = intensity_q;
		mul_b = weight_q;
		if (cfg.index == p2b_pkg::CFG_INTENSITY)
			mul_a = wdata8;
		if (cfg.index == p2b_pkg::CFG_WEIGHT)
			mul_b = weight_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cells_q <= p2b_pkg::ROW_CELLS_RST;
			invert_q    <= 1'b0;
			spaces_q    <= 1'b0;
			intensity_q <= p2b_pkg::INTENSITY_RST;
			alpha_q     <= p2b_pkg::ALPHA_RST;
			weight_q    <= p2b_pkg::WEIGHT_RST;
			limit_q     <= p2b_pkg::LIMIT_RST;
		end else if (wr) begin
			unique case (cfg.index)
				p2b_pkg::CFG_ROW_CELLS: row_cells_q <= cfg.data[p2b_pkg::ROW_CELLS_W-1:0];
				p2b_pkg::CFG_INVERT:    invert_q    <= cfg.data[0];
				p2b_pkg::CFG_SPACES:    spaces_q    <= cfg.data[0];
				p2b_pkg::CFG_INTENSITY: begin
					intensity_q <= wdata8;
					limit_q     <= p2b_pkg::LIMIT_W'(mul_a) * p2b_pkg::LIMIT_W'(mul_b);
				end
				p2b_pkg::CFG_ALPHA:     alpha_q     <= wdata8;
				p2b_pkg::CFG_WEIGHT: begin
					weight_q <= weight_new;
					limit_q  <= p2b_pkg::LIMIT_W'(mul_a) * p2b_pkg::LIMIT_W'(mul_b);
				end
				default: ;
			endcase
		end
	end

	assign cfg_o.row_cells  = row_cells_q;
	assign cfg_o.invert     = invert_q;
	assign cfg_o.use_spaces = spaces_q;
	assign cfg_o.alpha_thr  = alpha_q;
	assign cfg_o.limit      = limit_q;
endmodule

// ===== src/p2b_dpath.sv =====
// p2b_dpath: dot threshold, cell store read-modify-write, counters, output word.
// Depends on p2b_pkg and p2b_ram.
module p2b_dpath #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  p2b_pkg::cfg_t                 cfg_i,
	input  p2b_pkg::dp_cmd_t              cmd,
	output p2b_pkg::dp_stat_t             stat,
	input  logic [p2b_pkg::PIXEL_W-1:0]   pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [p2b_pkg::CODE_W-1:0]    out_code,
	output logic                          out_last
);
	localparam int CELL_DEPTH = MAX_WIDTH / 2;
	localparam int AW  = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
	localparam int CW  = AW + 1;
	localparam int CCW = $clog2(CELL_DEPTH + 1);
	localparam int KW  = (p2b_pkg::ROW_CELLS_W > CCW) ? p2b_pkg::ROW_CELLS_W : CCW;

	logic [CW-1:0] col_q;
	logic [1:0]    phase_q;
	logic          dot_q;

	logic [KW-1:0] rc_k;
	logic [KW-1:0] cells_k;
	logic [CW-1:0] lastcol;
	logic          row_end;

	logic [23:0]                 rgb;
	logic [31:0]                 flat;
	logic [p2b_pkg::SUM_W-1:0]   sum;
	logic                        dot;

	logic [7:0] rdata;
	logic [7:0] base;
	logic [7:0] cell_new;
	logic [2:0] bit_idx;
	logic       emit;

	logic                       out_valid_q;
	logic [p2b_pkg::CODE_W-1:0] out_code_q;
	logic                       out_last_q;
	logic                       out_free;

	// clamp row width to 1..CELL_DEPTH
	assign rc_k = KW'(cfg_i.row_cells);
	always_comb begin
		if (rc_k == '0)
			cells_k = KW'(1);
		else if (rc_k > KW'(CELL_DEPTH))
			cells_k = KW'(CELL_DEPTH);
		else
			cells_k = rc_k;
	end
	assign lastcol = CW'({cells_k, 1'b0} - (KW + 1)'(1));
	assign row_end = (col_q >= lastcol);

	// pixel to dot
	assign flat = (pixel[31:24] < cfg_i.alpha_thr) ? 32'hFFFF_FFFF : pixel;
	assign rgb  = cfg_i.invert ? ~flat[23:0] : flat[23:0];
	assign sum  = p2b_pkg::SUM_W'(rgb[7:0]) + p2b_pkg::SUM_W'(rgb[15:8])
	            + p2b_pkg::SUM_W'(rgb[23:16]);
	assign dot  = (p2b_pkg::LIMIT_W'(sum) < cfg_i.limit);

	always_ff @(posedge clk) begin
		if (cmd.capture)
			dot_q <= dot;
	end

	p2b_ram #(
		.WIDTH(8),
		.DEPTH(CELL_DEPTH)
	) u_cells (
		.clk    (clk),
		.we     (cmd.wr_en),
		.waddr  (col_q[CW-1:1]),
		.wdata  (cell_new),
		.re     (cmd.capture),
		.raddr  (col_q[CW-1:1]),
		.rdata_q(rdata)
	);

	// first pixel of a cell overwrites, the rest OR in
	assign bit_idx  = {col_q[0], phase_q};
	assign base     = (phase_q == 2'd0 && !col_q[0]) ? 8'd0 : rdata;
	assign cell_new = base | (8'(dot_q) << bit_idx);
	assign emit     = (phase_q == 2'd3) && col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= '0;
		end else if (cmd.step) begin
			if (row_end) begin
				col_q   <= '0;
				phase_q <= phase_q + 2'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// output word register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_last_q <= cmd.out_last;
			unique case (cmd.out_sel)
				p2b_pkg::OSEL_CELL:  out_code_q <= p2b_pkg::braille_code(cell_new);
				p2b_pkg::OSEL_SPACE: out_code_q <= p2b_pkg::CODE_SPACE;
				p2b_pkg::OSEL_CR:    out_code_q <= p2b_pkg::CODE_CR;
				p2b_pkg::OSEL_LF:    out_code_q <= p2b_pkg::CODE_LF;
				default:             out_code_q <= p2b_pkg::CODE_SPACE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_code  = out_code_q;
	assign out_last  = out_last_q;

	assign stat.emit       = emit;
	assign stat.row_end    = row_end;
	assign stat.out_free   = out_free;
	assign stat.use_spaces = cfg_i.use_spaces;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("output word overwritten while pending");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !row_end) |=> $stable(phase_q))
		else $error("row phase moved mid-row");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && row_end) |=> (col_q == '0))
		else $error("column not cleared at row end");
endmodule

// ===== src/p2b_ctrl.sv =====
// p2b_ctrl: sequencer for one pixel: capture, read-modify-write, separators.
// Depends on p2b_pkg.
module p2b_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  p2b_pkg::dp_stat_t    stat,
	output p2b_pkg::dp_cmd_t     cmd
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RMW  = 4'b0010,
		ST_SEP  = 4'b0100,
		ST_LF   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.capture  = 1'b0;
		cmd.wr_en    = 1'b0;
		cmd.load_out = 1'b0;
		cmd.out_sel  = p2b_pkg::OSEL_CELL;
		cmd.out_last = 1'b0;
		cmd.step     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid)
					state_d = ST_RMW;
			end
			ST_RMW: begin
				if (!stat.emit) begin
					cmd.wr_en = 1'b1;
					cmd.step  = 1'b1;
					state_d   = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.wr_en    = 1'b1;
					cmd.load_out = 1'b1;
					cmd.out_last = !stat.row_end;
					cmd.step     = !stat.row_end;
					state_d      = stat.row_end ? ST_SEP : ST_IDLE;
				end
			end
			ST_SEP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = stat.use_spaces ? p2b_pkg::OSEL_SPACE : p2b_pkg::OSEL_CR;
					cmd.out_last = stat.use_spaces;
					cmd.step     = stat.use_spaces;
					state_d      = stat.use_spaces ? ST_IDLE : ST_LF;
				end
			end
			ST_LF: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = p2b_pkg::OSEL_LF;
					cmd.out_last = 1'b1;
					cmd.step     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("second pixel taken before cell write");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !cmd.capture)
		else $error("counter step overlaps pixel capture");

	a_cell_word: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && stat.emit) |-> (cmd.load_out && cmd.out_sel == p2b_pkg::OSEL_CELL))
		else $error("cell finished without its braille word");
endmodule

// ===== src/pixel_to_braille_cells.sv =====
// pixel_to_braille_cells: top level, RGBA raster stream in, braille text out.
// Depends on p2b_pkg, the three channel interfaces, p2b_cfg, p2b_ctrl, p2b_dpath.
//
// Usage notes
//  - pix: one RGBA word per pixel, raster order, width = 2 * row_cells pixels.
//  - chr: braille code points, plus a space or CR,LF after each text row;
//    last marks the final word caused by a pixel.
//  - cfg: register writes (index, data), always ready; write only while idle.
//    threshold*weight product is refreshed on the write edge itself.
//  - Each pixel takes an accept step, then a read-modify-write of its cell,
//    paced by the single registered read port of the cell store. A pixel
//    that ends a text row adds a space, or a CR then an LF.
//  - A braille word becomes valid at the edge that ends the write state of
//    its pixel; separators follow one per cycle while the receiver is ready.
//  - A stalled receiver holds the output word; the sequencer waits in place
//    and takes no new pixel until all words of the current one are queued.
//    The pixel after the last word can be accepted while that word waits.
//  - Reset: config returns to defaults, column and row phase to zero. The
//    cell store is not cleared; row 0 of each text row writes every cell
//    before it is read, so no clearing pass is needed.
module pixel_to_braille_cells #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	p2b_pixel_if.sink  pix,
	p2b_char_if.source chr,
	p2b_cfg_if.sink    cfg
);
	p2b_pkg::cfg_t     cfg_w;
	p2b_pkg::dp_cmd_t  cmd;
	p2b_pkg::dp_stat_t stat;

	// configuration registers
	p2b_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.cfg_o (cfg_w)
	);

	// per-pixel sequencer
	p2b_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pix.valid),
		.in_ready(pix.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// threshold, cell store, counters and output word register
	p2b_dpath #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_i    (cfg_w),
		.cmd      (cmd),
		.stat     (stat),
		.pixel    (pix.pixel),
		.out_valid(chr.valid),
		.out_ready(chr.ready),
		.out_code (chr.char_code),
		.out_last (chr.last)
	);
endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for pixel_to_braille_cells. It streams RGBA pixels and
// checks each braille, space, CR and LF word against a cycle-free predictor.
// Depends on p2b_pkg, the pixel, char and cfg channel interfaces, and the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIDTH     = 4096;
	localparam int CELL_DEPTH    = MAX_WIDTH / 2;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 4;
	// covers the tail: the last cell write and any row-end separators
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_ITEMS  = 250;
	localparam int RANDOM_WORDS  = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int PRESSURE_PIX  = 64;

	// indexes with no register behind them, the block must ignore them
	localparam logic [p2b_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [p2b_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum int {
		PACE_SLOW_SINK,
		PACE_SLOW_SOURCE,
		PACE_FULL
	} pace_t;

	typedef struct {
		logic [p2b_pkg::CODE_W-1:0] code;
		logic                       last;
	} char_word_t;

	// Predictor of the block plus the queue of char words it still expects.
	class braille_scoreboard;
		logic [p2b_pkg::ROW_CELLS_W-1:0] row_cells;
		logic                            invert;
		logic                            spaces;
		logic [7:0]                      intensity;
		logic [7:0]                      alpha_thr;
		logic [7:0]                      weight;

		logic [7:0]                      cells [CELL_DEPTH];
		bit                              written [CELL_DEPTH];
		logic [p2b_pkg::ROW_CELLS_W-1:0] column;
		logic [1:0]                      phase;

		char_word_t             expected_chars [$];
		int unsigned            mismatches = 0;
		int unsigned            words_checked = 0;
		int unsigned            words_predicted = 0;
		int unsigned            pixels_seen = 0;

		function void clear();
			row_cells = p2b_pkg::ROW_CELLS_RST;
			invert    = 1'b0;
			spaces    = 1'b0;
			intensity = p2b_pkg::INTENSITY_RST;
			alpha_thr = p2b_pkg::ALPHA_RST;
			weight    = p2b_pkg::WEIGHT_RST;
			foreach (written[i])
				written[i] = 1'b0;
			column = '0;
			phase  = '0;
			expected_chars.delete();
		endfunction

		function void write_reg(input logic [p2b_pkg::CFG_IDX_W-1:0] idx,
				input logic [p2b_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				p2b_pkg::CFG_ROW_CELLS: row_cells = data[p2b_pkg::ROW_CELLS_W-1:0];
				p2b_pkg::CFG_INVERT:    invert    = data[0];
				p2b_pkg::CFG_SPACES:    spaces    = data[0];
				p2b_pkg::CFG_INTENSITY: intensity = data[7:0];
				p2b_pkg::CFG_ALPHA:     alpha_thr = data[7:0];
				p2b_pkg::CFG_WEIGHT:    weight    = data[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_cells(input logic [p2b_pkg::ROW_CELLS_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > CELL_DEPTH)
				return CELL_DEPTH;
			return v;
		endfunction

		// A new width is safe if no cell read before its next write is unwritten.
		function bit width_ok(input logic [p2b_pkg::ROW_CELLS_W-1:0] v);
			int unsigned n;
			n = eff_cells(v);
			if (phase == 0)
				return 1'b1;
			for (int unsigned i = 0; i < n; i++)
				if (!written[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function bit dot(input logic [p2b_pkg::PIXEL_W-1:0] px);
			logic [p2b_pkg::PIXEL_W-1:0] p;
			int unsigned sum;
			int unsigned div;
			p = px;
			if (p[31:24] < alpha_thr)
				p = '1;
			if (invert)
				p[23:0] = ~p[23:0];
			sum = p[7:0] + p[15:8] + p[23:16];
			div = (weight == 0) ? 1 : weight;
			return (sum / div) < intensity;
		endfunction

		function logic [p2b_pkg::CODE_W-1:0] cell_char(input logic [7:0] v);
			logic [7:0] r;
			if (v == 0)
				return p2b_pkg::EMPTY_CODE;
			r = v & 8'h87;
			r[3] = v[4];
			r[4] = v[5];
			r[5] = v[6];
			r[6] = v[3];
			return p2b_pkg::BRAILLE_BASE + p2b_pkg::CODE_W'(r);
		endfunction

		function void push(input logic [p2b_pkg::CODE_W-1:0] code, input logic last);
			expected_chars.push_back('{code, last});
			words_predicted++;
		endfunction

		function void take_pixel(input logic [p2b_pkg::PIXEL_W-1:0] px);
			int unsigned lastcol;
			int unsigned idx;
			int unsigned pos;
			bit d;
			bit row_end;
			lastcol = eff_cells(row_cells) * 2 - 1;
			row_end = (column >= lastcol);
			idx = column >> 1;
			pos = (column[0] ? 4 : 0) + phase;
			d = dot(px);
			if (phase == 0 && !column[0]) begin
				cells[idx] = 8'(d) << pos;
				written[idx] = 1'b1;
			end else begin
				cells[idx] = cells[idx] | (8'(d) << pos);
			end
			if (phase == 3 && column[0]) begin
				push(cell_char(cells[idx]), !row_end);
				if (row_end) begin
					if (spaces) begin
						push(p2b_pkg::CODE_SPACE, 1'b1);
					end else begin
						push(p2b_pkg::CODE_CR, 1'b0);
						push(p2b_pkg::CODE_LF, 1'b1);
					end
				end
			end
			if (row_end) begin
				column = '0;
				phase = phase + 1'b1;
			end else begin
				column = column + 1'b1;
			end
			pixels_seen++;
		endfunction

		function void check_char(input logic [p2b_pkg::CODE_W-1:0] code, input logic last);
			char_word_t want;
			words_checked++;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("char word %0d unexpected: code %h last %b",
						words_checked, code, last);
				return;
			end
			want = expected_chars.pop_front();
			if (code !== want.code || last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("char word %0d: expected code %h last %b, got code %h last %b",
						words_checked, want.code, want.last, code, last);
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	p2b_pixel_if pix();
	p2b_char_if  chr();
	p2b_cfg_if   cfg();

	pixel_to_braille_cells #(
		.MAX_WIDTH(MAX_WIDTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.chr    (chr),
		.cfg    (cfg)
	);

	braille_scoreboard board = new();

	int unsigned source_idle_pct = 0;
	int unsigned sink_idle_pct   = 0;
	int unsigned hold_left       = 0;
	int unsigned cycle_count     = 0;
	int unsigned settings_applied = 0;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run guard: a stuck handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d char words still expected",
				cycle_count, board.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			chr.ready <= 1'b0;
		end else if (hold_left != 0) begin
			chr.ready <= 1'b0;
			hold_left--;
		end else begin
			chr.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Monitor: values read right after the edge are the ones the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (chr.valid && chr.ready)
				board.check_char(chr.char_code, chr.last);
			if (pix.valid && pix.ready)
				board.take_pixel(pix.pixel);
			if (cfg.valid && cfg.ready)
				board.write_reg(cfg.index, cfg.data);
		end
	end

	task automatic set_pace(input pace_t p);
		case (p)
			PACE_SLOW_SINK: begin
				source_idle_pct = 34;
				sink_idle_pct   = 79;
			end
			PACE_SLOW_SOURCE: begin
				source_idle_pct = 79;
				sink_idle_pct   = 34;
			end
			default: begin
				source_idle_pct = 0;
				sink_idle_pct   = 0;
			end
		endcase
	endtask

	// valid stays high between back-to-back words; it drops only for a gap
	task automatic send_pixel(input logic [p2b_pkg::PIXEL_W-1:0] px);
		if ($urandom_range(0, 99) < source_idle_pct) begin
			pix.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < source_idle_pct);
		end
		pix.valid <= 1'b1;
		pix.pixel <= px;
		do @(posedge clk); while (!pix.ready);
	endtask

	// Wait until every predicted word is out, then let the block settle.
	// The outer loop covers a pixel accepted on the edge we started from.
	task automatic wait_idle();
		pix.valid <= 1'b0;
		do begin
			while (board.pending() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end while (board.pending() != 0);
	endtask

	task automatic cfg_write(input logic [p2b_pkg::CFG_IDX_W-1:0] idx,
			input logic [p2b_pkg::CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// All six registers in one burst; unused upper data bits carry noise.
	task automatic apply_setting(input logic [p2b_pkg::ROW_CELLS_W-1:0] cells_v,
			input logic inv, input logic spc, input logic [7:0] thr,
			input logic [7:0] alpha, input logic [7:0] wt);
		cfg_write(p2b_pkg::CFG_ROW_CELLS, cells_v);
		cfg_write(p2b_pkg::CFG_INVERT, {11'($urandom), inv});
		cfg_write(p2b_pkg::CFG_SPACES, {11'($urandom), spc});
		cfg_write(p2b_pkg::CFG_INTENSITY, {4'($urandom), thr});
		cfg_write(p2b_pkg::CFG_ALPHA, {4'($urandom), alpha});
		cfg_write(p2b_pkg::CFG_WEIGHT, {4'($urandom), wt});
		cfg.valid <= 1'b0;
		settings_applied++;
	endtask

	// Mix of raw noise, saturated corners and near-gray pixels so that the
	// threshold compare lands on both sides.
	function automatic logic [p2b_pkg::PIXEL_W-1:0] rand_pixel();
		logic [7:0] g;
		g = 8'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3: return 32'hFF00_0000;
			4: return 32'hFFFF_FFFF;
			5: return {8'($urandom), 24'h00_0000};
			default: return {8'($urandom), g ^ 8'($urandom_range(0, 15)), g,
				g ^ 8'($urandom_range(0, 15))};
		endcase
	endfunction

	function automatic logic [7:0] rand_threshold();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(40, 200));
		endcase
	endfunction

	function automatic logic [7:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			default: return 8'($urandom_range(1, 4));
		endcase
	endfunction

	initial begin
		logic [p2b_pkg::ROW_CELLS_W-1:0] cells_v;
		int unsigned eff;
		int unsigned n_pix;
		int unsigned random_items;
		int unsigned words_base;
		int leftover;
		bit pressure_done;

		arst_n    <= 1'b0;
		pix.valid <= 1'b0;
		pix.pixel <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data  <= '0;
		board.clear();
		pressure_done = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		//------------------------------------------------------------------
		// Directed part
		//------------------------------------------------------------------
		set_pace(PACE_SLOW_SINK);
		wait_idle();

		// One-cell rows, all white: the empty cell maps to 0x2804, then CR,LF.
		apply_setting(12'd1, 1'b0, 1'b0, 8'd128, 8'd64, 8'd3);
		repeat (8) send_pixel(32'hFFFF_FFFF);

		// Width zero behaves as one cell; inversion, space separator, weight
		// zero and the top of both thresholds. Corner pixels, including an
		// alpha just under the threshold that flattens to white.
		wait_idle();
		apply_setting(12'd0, 1'b1, 1'b1, 8'd255, 8'd255, 8'd0);
		send_pixel(32'hFF00_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'h00FF_FFFF);
		send_pixel(32'hFE00_0000);
		send_pixel(32'hFF80_8080);
		send_pixel(32'h7F12_3456);
		send_pixel(32'h80FF_FFFF);

		// Width shrinks in the middle of a pixel row: the next column is past
		// the new last column and must end the row.
		wait_idle();
		apply_setting(12'd3, 1'b0, 1'b0, 8'd1, 8'd0, 8'd255);
		repeat (3) send_pixel(rand_pixel());
		wait_idle();
		cfg_write(p2b_pkg::CFG_ROW_CELLS, 12'd1);
		cfg_write(CFG_SPARE_LO, 12'($urandom));
		cfg_write(CFG_SPARE_HI, 12'($urandom));
		cfg.valid <= 1'b0;
		repeat (7) send_pixel(rand_pixel());

		// Largest width field, clamped to the store depth: a short pixel row
		// must not end early. Shrinking to one cell then ends the row and
		// narrow rows finish the text row.
		wait_idle();
		apply_setting(12'hFFF, 1'($urandom), 1'($urandom), rand_threshold(),
			8'($urandom), rand_weight());
		repeat (7) send_pixel(rand_pixel());
		wait_idle();
		apply_setting(12'd1, 1'($urandom), 1'($urandom), rand_threshold(),
			8'($urandom), rand_weight());
		repeat (7) send_pixel(rand_pixel());

		//------------------------------------------------------------------
		// Random part: each phase picks a setting, then whole text rows, now
		// and then cut short so the next setting lands mid row.
		//------------------------------------------------------------------
		random_items = 0;
		words_base = board.words_predicted;
		while (random_items < RANDOM_ITEMS ||
				board.words_predicted - words_base < RANDOM_WORDS) begin
			if (random_items < RANDOM_ITEMS / 3)
				set_pace(PACE_SLOW_SINK);
			else if (random_items < 2 * RANDOM_ITEMS / 3)
				set_pace(PACE_SLOW_SOURCE);
			else
				set_pace(PACE_FULL);

			wait_idle();
			case ($urandom_range(0, 19))
				0: cells_v = 12'd0;
				1: cells_v = 12'($urandom_range(9, 16));
				default: cells_v = 12'($urandom_range(1, 6));
			endcase
			// never grow into cells this text row has not written yet
			if (!board.width_ok(cells_v))
				cells_v = board.row_cells;

			// Pressure: one-cell rows give words often; the receiver holds off
			// while the sender keeps offering, so the block must stall input.
			if (source_idle_pct == 0 && !pressure_done && board.width_ok(12'd1)) begin
				cells_v = 12'd1;
				apply_setting(cells_v, 1'($urandom), 1'($urandom), rand_threshold(),
					8'($urandom), rand_weight());
				hold_left = HOLD_CYCLES;
				pressure_done = 1'b1;
				n_pix = PRESSURE_PIX;
			end else begin
				apply_setting(cells_v, 1'($urandom), 1'($urandom), rand_threshold(),
					8'($urandom), rand_weight());
				eff = board.eff_cells(cells_v);
				n_pix = (eff > 6 ? 1 : $urandom_range(1, 3)) * 8 * eff;
				if ($urandom_range(0, 3) == 0)
					n_pix += $urandom_range(1, 8 * eff - 1);
			end
			repeat (n_pix) begin
				send_pixel(rand_pixel());
				random_items++;
			end
		end

		//------------------------------------------------------------------
		// Drain and verdict
		//------------------------------------------------------------------
		pix.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		leftover = board.pending();
		if (leftover != 0)
			$display("%0d expected char words never arrived", leftover);

		$display("Covered %0d pixels, %0d char words checked, %0d register settings.",
			board.pixels_seen, board.words_checked, settings_applied);
		$display("Included zero and oversized widths, a mid-row shrink and a long hold-off.");
		if (board.mismatches == 0 && leftover == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
